### rtl/bmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter package
// Shared widths, reset values and the structs passed between the filter's
// modules.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // Defaults for the top-level size parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 7;

    // Field widths of the channels and registers.
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int RAD_W     = 3;
    localparam int COL_OUT_W = 10;
    localparam int ROW_OUT_W = 10;
    localparam int MEAN_W    = 16;

    // Row ring and column sum storage.
    localparam int ROW_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int CS_W      = 12;

    // Register reset values.
    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd1024;
    localparam logic [RAD_W-1:0] RADIUS_RST = 3'd1;

    // Configuration as written by software.
    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [RAD_W-1:0] window_radius;
    } t_cfg;

    // One filtered pixel.
    typedef struct packed {
        logic [COL_OUT_W-1:0] out_column;
        logic [ROW_OUT_W-1:0] out_row;
        logic [MEAN_W-1:0]    mean_value;
        logic                 last_of_run;
    } t_result;

endpackage

### rtl/bmf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter channels
// Valid/ready channels for incoming pixels and outgoing filtered pixels.
// ----------------------------------------------------------------------------

// Pixel input channel.
interface bmf_pix_if import bmf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

// Filtered pixel output channel.
interface bmf_res_if import bmf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] out_column;
    logic [ROW_OUT_W-1:0] out_row;
    logic [MEAN_W-1:0]    mean_value;
    logic                 last_of_run;

    modport source (output valid, output out_column, output out_row, output mean_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_column, input out_row, input mean_value,
                    input last_of_run, output ready);
endinterface

### rtl/box_mean_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter core
// Streaming box mean filter for 8-bit gray pixels with an APB register port.
// ----------------------------------------------------------------------------
// Pixels enter in raster order one per transaction; each filtered pixel leaves
// as an 8.8 fixed-point window mean as soon as the last pixel of its window has
// arrived, so row and frame ends release bursts whose final result carries
// last_of_run. One sequencer drives the column sum memory and the row ring
// memory: a pixel that releases nothing only updates both memories, and each
// released result reads the column sums of its window, strips the rows clipped
// away at the top, runs the 24-step area divider and is then handed out. After
// reset the column sums are cleared, and no pixel is taken until that is done.
// Registers: image_width at 0x0, image_height at 0x4, window_radius at 0x8;
// write them only while idle.
// ----------------------------------------------------------------------------
module box_mean_filter_core import bmf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmf_pix_if.sink     i_pix,
    bmf_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2
    } t_reg_idx;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_ovalid;
    t_result r_ores;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= WIDTH_RST;
            r_cfg.image_height  <= HEIGHT_RST;
            r_cfg.window_radius <= RADIUS_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_IMAGE_WIDTH:   r_cfg.image_width   <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT:  r_cfg.image_height  <= pwdata[CFG_W-1:0];
                REG_WINDOW_RADIUS: r_cfg.window_radius <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_IMAGE_WIDTH:   prdata = 32'(r_cfg.image_width);
            REG_IMAGE_HEIGHT:  prdata = 32'(r_cfg.image_height);
            REG_WINDOW_RADIUS: prdata = 32'(r_cfg.window_radius);
            default:           prdata = '0;
        endcase
    end

    // Filter engine.
    bmf_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix       (i_pix),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register decouples the engine from the result sink.
    assign res_ready = !r_ovalid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_ores <= res;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.out_column  = r_ores.out_column;
    assign o_res.out_row     = r_ores.out_row;
    assign o_res.mean_value  = r_ores.mean_value;
    assign o_res.last_of_run = r_ores.last_of_run;

endmodule

### rtl/bmf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmf_div import bmf_pkg::*; #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W:0]   rem_sub;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // Control: busy flag, step count and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts in from the right as the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/bmf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter engine
// Holds the column sum memory and the row ring memory, updates them for each
// pixel and walks the windows that the pixel completes.
// ----------------------------------------------------------------------------
module bmf_engine import bmf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    bmf_pix_if.sink       i_pix,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res
);

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int RW      = $clog2(MAX_HEIGHT + 1);
    localparam int KW      = $clog2(2 * MAX_RADIUS + 2);
    localparam int AREA_W  = 2 * KW;
    localparam int SUM_W   = CS_W + KW;
    localparam int NUM_W   = SUM_W + 8;
    localparam int CMPW_W  = (CW > CFG_W) ? CW : CFG_W;
    localparam int CMPH_W  = (RW > CFG_W) ? RW : CFG_W;
    localparam int RS_DEPTH = ROW_SLOTS << AW;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_UPD    = 10'b0000000100,
        S_OSTART = 10'b0000001000,
        S_CRD    = 10'b0000010000,
        S_CDAT   = 10'b0000100000,
        S_SDAT   = 10'b0001000000,
        S_DSTART = 10'b0010000000,
        S_DWAIT  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    // Memories.
    logic [CS_W-1:0]  m_colsum [MAX_WIDTH];
    logic [PIX_W-1:0] m_rows   [RS_DEPTH];

    logic                   cs_re, cs_we, rs_re, rs_we;
    logic [AW-1:0]          cs_raddr, cs_waddr;
    logic [CS_W-1:0]        cs_wdata, cs_q;
    logic [SLOT_W+AW-1:0]   rs_raddr, rs_waddr;
    logic [PIX_W-1:0]       rs_wdata, rs_q;

    // Registers.
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [CW-1:0]     r_in_col, n_in_col;
    logic [RW-1:0]     r_in_row, n_in_row;
    logic [PIX_W-1:0]  r_px, n_px;
    logic [AW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_w, n_w;
    logic [RW-1:0]     r_h, n_h;
    logic [RAD_W-1:0]  r_r, n_r;
    logic [RW-1:0]     r_oy_lo, n_oy_lo, r_oy_hi, n_oy_hi, r_oy, n_oy;
    logic [AW-1:0]     r_ox_lo, n_ox_lo, r_ox_hi, n_ox_hi, r_ox, n_ox;
    logic [AW-1:0]     r_x, n_x;
    logic [RW-1:0]     r_yy, n_yy;
    logic [RW-1:0]     r_base, n_base;
    logic [CS_W-1:0]   r_s, n_s;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [MEAN_W-1:0] r_mean, n_mean;

    // Combinational helpers.
    logic [CMPW_W-1:0] w_raw;
    logic [CMPH_W-1:0] h_raw;
    logic [CW-1:0]     w_c;
    logic [RW-1:0]     h_c;
    logic [RAD_W-1:0]  r_c;
    logic [CW-1:0]     p_col;
    logic [RW-1:0]     p_row;
    logic [SLOT_W-1:0] old_slot;
    logic [CS_W-1:0]   cs_new;
    logic [RW-1:0]     ry, ry2;
    logic [AW-1:0]     rx;
    logic [RW-1:0]     y0;
    logic [AW-1:0]     x0;
    logic [CS_W-1:0]   s_sub;
    logic [KW-1:0]     dxp, dyp;
    logic [AREA_W-1:0] area;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quot;
    logic              accept;

    // Clamp the written configuration to the supported range.
    always_comb begin
        w_raw = CMPW_W'(i_cfg.image_width);
        h_raw = CMPH_W'(i_cfg.image_height);
        if (w_raw == '0) begin
            w_c = CW'(1);
        end else if (w_raw > CMPW_W'(MAX_WIDTH)) begin
            w_c = CW'(MAX_WIDTH);
        end else begin
            w_c = CW'(w_raw);
        end
        if (h_raw == '0) begin
            h_c = RW'(1);
        end else if (h_raw > CMPH_W'(MAX_HEIGHT)) begin
            h_c = RW'(MAX_HEIGHT);
        end else begin
            h_c = RW'(h_raw);
        end
        r_c = (i_cfg.window_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                         : i_cfg.window_radius;
    end

    // Position of the incoming pixel, with row and frame wrap.
    always_comb begin
        p_col = r_in_col;
        p_row = r_in_row;
        if (i_pix.frame_start) begin
            p_col = '0;
            p_row = '0;
        end else begin
            if (p_col >= w_c) begin
                p_col = '0;
                p_row = r_in_row + RW'(1);
            end
            if (p_row >= h_c) begin
                p_row = '0;
            end
        end
        old_slot = p_row[SLOT_W-1:0] - SLOT_W'({r_c, 1'b1});
    end

    // Window geometry from the latched radius and the current output pixel.
    always_comb begin
        ry   = RW'(r_r);
        ry2  = RW'({r_r, 1'b0});
        rx   = AW'(r_r);
        y0   = (r_oy > ry) ? r_oy - ry : '0;
        x0   = (r_ox > rx) ? r_ox - rx : '0;
        dxp  = KW'(r_col - x0) + KW'(1);
        dyp  = KW'(r_row - y0) + KW'(1);
        area = AREA_W'(dxp) * AREA_W'(dyp);
        if (r_row == '0) begin
            cs_new = CS_W'(r_px);
        end else if (r_row >= ry2 + RW'(1)) begin
            cs_new = cs_q + CS_W'(r_px) - CS_W'(rs_q);
        end else begin
            cs_new = cs_q + CS_W'(r_px);
        end
        s_sub = r_s - CS_W'(rs_q);
    end

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign div_num     = {r_sum, 8'd0};

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_px     = r_px;
        n_col    = r_col;
        n_row    = r_row;
        n_w      = r_w;
        n_h      = r_h;
        n_r      = r_r;
        n_oy_lo  = r_oy_lo;
        n_oy_hi  = r_oy_hi;
        n_oy     = r_oy;
        n_ox_lo  = r_ox_lo;
        n_ox_hi  = r_ox_hi;
        n_ox     = r_ox;
        n_x      = r_x;
        n_yy     = r_yy;
        n_base   = r_base;
        n_s      = r_s;
        n_sum    = r_sum;
        n_mean   = r_mean;
        cs_re    = 1'b0;
        cs_we    = 1'b0;
        cs_raddr = r_x;
        cs_waddr = r_col;
        cs_wdata = cs_new;
        rs_re    = 1'b0;
        rs_we    = 1'b0;
        rs_raddr = {r_yy[SLOT_W-1:0], r_x};
        rs_waddr = {r_row[SLOT_W-1:0], r_col};
        rs_wdata = r_px;
        div_start   = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            // Zero the column sums once after reset.
            S_CLEAR: begin
                cs_we    = 1'b1;
                cs_waddr = r_clr;
                cs_wdata = '0;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(MAX_WIDTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // Take a pixel and fetch its column sum and the row leaving the window.
            S_IDLE: begin
                if (accept) begin
                    cs_re    = 1'b1;
                    cs_raddr = p_col[AW-1:0];
                    rs_re    = 1'b1;
                    rs_raddr = {old_slot, p_col[AW-1:0]};
                    n_px     = i_pix.pixel_value;
                    n_col    = p_col[AW-1:0];
                    n_row    = p_row;
                    n_w      = w_c;
                    n_h      = h_c;
                    n_r      = r_c;
                    n_in_col = p_col + CW'(1);
                    n_in_row = p_row;
                    n_state  = S_UPD;
                end
            end
            // Write back the column sum and the pixel, then find released outputs.
            S_UPD: begin
                cs_we   = 1'b1;
                rs_we   = 1'b1;
                n_state = S_OSTART;
                n_base  = (r_row >= ry2) ? r_row - ry2 : '0;
                if (r_row < r_h - RW'(1)) begin
                    n_oy_lo = r_row - ry;
                    n_oy_hi = r_row - ry;
                    if (r_row < ry) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_oy_lo = (r_row >= ry) ? r_row - ry : '0;
                    n_oy_hi = r_row;
                end
                if (CW'(r_col) < r_w - CW'(1)) begin
                    n_ox_lo = r_col - rx;
                    n_ox_hi = r_col - rx;
                    if (r_col < rx) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_ox_lo = (r_col >= rx) ? r_col - rx : '0;
                    n_ox_hi = r_col;
                end
                n_oy = n_oy_lo;
                n_ox = n_ox_lo;
            end
            // Start the window sum of one output pixel.
            S_OSTART: begin
                n_x     = x0;
                n_sum   = '0;
                n_state = S_CRD;
            end
            S_CRD: begin
                cs_re   = 1'b1;
                n_state = S_CDAT;
            end
            // Column sum arrived; strip rows above the clipped window if any.
            S_CDAT: begin
                if (r_base < y0) begin
                    rs_re    = 1'b1;
                    rs_raddr = {r_base[SLOT_W-1:0], r_x};
                    n_yy     = r_base + RW'(1);
                    n_s      = cs_q;
                    n_state  = S_SDAT;
                end else begin
                    n_sum = r_sum + SUM_W'(cs_q);
                    if (r_x == r_col) begin
                        n_state = S_DSTART;
                    end else begin
                        n_x     = r_x + AW'(1);
                        n_state = S_CRD;
                    end
                end
            end
            S_SDAT: begin
                if (r_yy < y0) begin
                    rs_re = 1'b1;
                    n_yy  = r_yy + RW'(1);
                    n_s   = s_sub;
                end else begin
                    n_sum = r_sum + SUM_W'(s_sub);
                    if (r_x == r_col) begin
                        n_state = S_DSTART;
                    end else begin
                        n_x     = r_x + AW'(1);
                        n_state = S_CRD;
                    end
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DWAIT;
            end
            // Saturate the quotient to the result width.
            S_DWAIT: begin
                if (div_done) begin
                    n_mean  = (|div_quot[NUM_W-1:MEAN_W]) ? '1 : div_quot[MEAN_W-1:0];
                    n_state = S_OUT;
                end
            end
            // Hand the result over and step to the next output pixel.
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_OSTART;
                    if (r_ox == r_ox_hi) begin
                        n_ox = r_ox_lo;
                        n_oy = r_oy + RW'(1);
                        if (r_oy == r_oy_hi) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_ox = r_ox + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result of the current output pixel.
    always_comb begin
        o_res.out_column  = COL_OUT_W'(r_ox);
        o_res.out_row     = ROW_OUT_W'(r_oy);
        o_res.mean_value  = r_mean;
        o_res.last_of_run = (r_ox == r_ox_hi) && (r_oy == r_oy_hi);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_in_col <= '0;
            r_in_row <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_col   <= n_col;
        r_row   <= n_row;
        r_w     <= n_w;
        r_h     <= n_h;
        r_r     <= n_r;
        r_oy_lo <= n_oy_lo;
        r_oy_hi <= n_oy_hi;
        r_oy    <= n_oy;
        r_ox_lo <= n_ox_lo;
        r_ox_hi <= n_ox_hi;
        r_ox    <= n_ox;
        r_x     <= n_x;
        r_yy    <= n_yy;
        r_base  <= n_base;
        r_s     <= n_s;
        r_sum   <= n_sum;
        r_mean  <= n_mean;
    end

    // Column sum memory.
    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            m_colsum[cs_waddr] <= cs_wdata;
        end
        if (cs_re) begin
            cs_q <= m_colsum[cs_raddr];
        end
    end

    // Row ring memory, the last sixteen rows.
    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            m_rows[rs_waddr] <= rs_wdata;
        end
        if (rs_re) begin
            rs_q <= m_rows[rs_raddr];
        end
    end

    // Area division.
    bmf_div #(
        .NUM_W (NUM_W),
        .DEN_W (AREA_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (area),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule
